// ===== hw/rtl/spq_pkg.sv =====
// Shared constants and types for the stable priority ready queue.
// No dependencies; imported by the top level.
package spq_pkg;

    // Queue geometry and entry field widths.
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int PRIO_BITS   = 8;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W     = ID_BITS + PRIO_BITS;

    // Operation codes carried on the func field.
    typedef enum logic {
        FUNC_INSERT  = 1'b0,
        FUNC_EXTRACT = 1'b1
    } func_t;

    // Status codes returned with every result.
    typedef enum logic [1:0] {
        ST_EXTRACTED = 2'd0,
        ST_INSERTED  = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

endpackage

// ===== hw/rtl/spq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module spq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write when enabled; read data is registered every cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/stable_priority_ready_queue.sv =====
// Top level of the stable priority ready queue.
// Depends on spq_pkg and spq_ram.

// The queue holds up to 16 entries (task id and priority) in arrival order in a
// small RAM. An extract walks the RAM once from the oldest entry to find the
// first entry with the smallest priority, then moves every later entry down one
// place to close the gap. The entry RAM has a single read port, so one entry is
// read per cycle. The input is ready only while no operation is in progress, and
// a finished result waits in the output register until it is taken. Extract on
// an empty queue returns status empty and insert into a full queue returns
// status full, both with zero id and priority.
module stable_priority_ready_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         func,
    input  logic [spq_pkg::ID_BITS-1:0]   task_id,
    input  logic [spq_pkg::PRIO_BITS-1:0] prio,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [spq_pkg::ID_BITS-1:0]   out_task_id,
    output logic [spq_pkg::PRIO_BITS-1:0] out_prio,
    output logic [1:0]                   status,
    output logic [spq_pkg::CNT_W-1:0]     occupancy
);

    import spq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_RD,
        S_SHIFT,
        S_FIN
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]     best_reg, best_next;
    logic [ID_BITS-1:0]   best_id_reg, best_id_next;
    logic [PRIO_BITS-1:0] best_prio_reg, best_prio_next;
    logic [IDX_W-1:0]     wr_idx_reg, wr_idx_next;
    status_t              res_status_reg, res_status_next;
    logic                 out_valid_reg, out_valid_next;
    logic [ID_BITS-1:0]   out_id_reg, out_id_next;
    logic [PRIO_BITS-1:0] out_prio_reg, out_prio_next;
    status_t              out_status_reg, out_status_next;
    logic [CNT_W-1:0]     out_occ_reg, out_occ_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [ID_BITS-1:0]   rd_id;
    logic [PRIO_BITS-1:0] rd_prio;
    logic                 in_xfer;
    logic                 out_xfer;

    // Entry storage, packed as id over priority.
    spq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_id    = ram_rdata[ENTRY_W-1:PRIO_BITS];
    assign rd_prio  = ram_rdata[PRIO_BITS-1:0];
    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid_reg && out_ready;

    // Sequencer: next state, RAM port control and result capture.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        best_next       = best_reg;
        best_id_next    = best_id_reg;
        best_prio_next  = best_prio_reg;
        wr_idx_next     = wr_idx_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_xfer;
        out_id_next     = out_id_reg;
        out_prio_next   = out_prio_reg;
        out_status_next = out_status_reg;
        out_occ_next    = out_occ_reg;
        ram_we          = 1'b0;
        ram_waddr       = wr_idx_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    best_id_next   = '0;
                    best_prio_next = '0;
                    if (func == FUNC_INSERT)
                    begin
                        if (count_reg == CNT_W'(QUEUE_DEPTH))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_we          = 1'b1;
                            ram_waddr       = count_reg[IDX_W-1:0];
                            ram_wdata       = {task_id, prio};
                            count_next      = count_reg + CNT_W'(1);
                            res_status_next = ST_INSERTED;
                        end
                        state_next = S_FIN;
                    end
                    else if (count_reg == '0)
                    begin
                        res_status_next = ST_EMPTY;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        // Oldest entry is read first.
                        ram_raddr     = '0;
                        scan_idx_next = '0;
                        state_next    = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Strict compare keeps the earliest of equal priorities.
                if (scan_idx_reg == '0 || rd_prio < best_prio_reg)
                begin
                    best_next      = scan_idx_reg;
                    best_id_next   = rd_id;
                    best_prio_next = rd_prio;
                end
                ram_raddr = scan_idx_reg + IDX_W'(1);
                if (CNT_W'(scan_idx_reg) + CNT_W'(1) == count_reg)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end

            S_SHIFT_RD:
            begin
                res_status_next = ST_EXTRACTED;
                if (CNT_W'(best_reg) + CNT_W'(1) == count_reg)
                begin
                    // The chosen entry is the newest: nothing to close up.
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_FIN;
                end
                else
                begin
                    ram_raddr   = best_reg + IDX_W'(1);
                    wr_idx_next = best_reg;
                    state_next  = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                // Move the entry read last cycle down one place.
                ram_we    = 1'b1;
                ram_waddr = wr_idx_reg;
                ram_wdata = ram_rdata;
                ram_raddr = wr_idx_reg + IDX_W'(2);
                if (CNT_W'(wr_idx_reg) + CNT_W'(2) == count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_FIN;
                end
                else
                begin
                    wr_idx_next = wr_idx_reg + IDX_W'(1);
                end
            end

            S_FIN:
            begin
                // Load the output register once it is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_id_next     = best_id_reg;
                    out_prio_next   = best_prio_reg;
                    out_status_next = res_status_reg;
                    out_occ_next    = count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            scan_idx_reg   <= '0;
            best_reg       <= '0;
            best_id_reg    <= '0;
            best_prio_reg  <= '0;
            wr_idx_reg     <= '0;
            res_status_reg <= ST_EMPTY;
            out_valid_reg  <= 1'b0;
            out_id_reg     <= '0;
            out_prio_reg   <= '0;
            out_status_reg <= ST_EMPTY;
            out_occ_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            scan_idx_reg   <= scan_idx_next;
            best_reg       <= best_next;
            best_id_reg    <= best_id_next;
            best_prio_reg  <= best_prio_next;
            wr_idx_reg     <= wr_idx_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_id_reg     <= out_id_next;
            out_prio_reg   <= out_prio_next;
            out_status_reg <= out_status_next;
            out_occ_reg    <= out_occ_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_task_id = out_id_reg;
    assign out_prio    = out_prio_reg;
    assign status      = out_status_reg;
    assign occupancy   = out_occ_reg;

endmodule

// ===== tb/sv/stable_priority_ready_queue_tb.sv =====
// Testbench for the stable priority ready queue: directed and random inserts and extracts.
// It checks every result against an in-bench model of the queue.
// Depends on spq_pkg and the stable_priority_ready_queue RTL.
`timescale 1ns / 100ps

module stable_priority_ready_queue_tb;

    import spq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;
    localparam int RANDOM_ITEMS = 930;

    // One expected dispatch result.
    typedef struct packed {
        logic [ID_BITS-1:0]   task_id;
        logic [PRIO_BITS-1:0] prio;
        status_t              status;
        logic [CNT_W-1:0]     occupancy;
    } dispatch_t;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_EVERY_FIFTH,
        RX_SPARSE
    } rx_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    func_t                func = FUNC_INSERT;
    logic [ID_BITS-1:0]   task_id = '0;
    logic [PRIO_BITS-1:0] prio = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [ID_BITS-1:0]   out_task_id;
    logic [PRIO_BITS-1:0] out_prio;
    logic [1:0]           status;
    logic [CNT_W-1:0]     occupancy;

    // Model of the queue contents, oldest entry at index zero.
    logic [ID_BITS-1:0]   model_ids [QUEUE_DEPTH];
    logic [PRIO_BITS-1:0] model_prios [QUEUE_DEPTH];
    int                   model_count = 0;

    dispatch_t            pending_dispatches [$];
    dispatch_t            oldest_dispatch;
    int                   error_count = 0;
    int                   cycle_count = 0;
    int                   burst_left = 0;

    rx_mode_t             rx_mode = RX_ALWAYS;
    int                   rx_phase_left = 0;
    int                   rx_tick = 0;

    stable_priority_ready_queue u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .task_id     (task_id),
        .prio        (prio),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_task_id (out_task_id),
        .out_prio    (out_prio),
        .status      (status),
        .occupancy   (occupancy)
    );

    // Free-running clock, 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Apply one operation to the model and return the result it should produce.
    function automatic dispatch_t model_dispatch(input func_t op,
                                                 input logic [ID_BITS-1:0] id,
                                                 input logic [PRIO_BITS-1:0] pr);
        dispatch_t r;
        int        best;
        int        i;
        r.task_id = '0;
        r.prio = '0;
        if (op == FUNC_INSERT)
        begin
            if (model_count >= QUEUE_DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                model_ids[model_count] = id;
                model_prios[model_count] = pr;
                model_count++;
                r.status = ST_INSERTED;
            end
        end
        else if (model_count == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            // Strict compare keeps the oldest entry among equal priorities.
            best = 0;
            for (i = 1; i < model_count; i++)
            begin
                if (model_prios[i] < model_prios[best])
                    best = i;
            end
            r.task_id = model_ids[best];
            r.prio = model_prios[best];
            for (i = best; i + 1 < model_count; i++)
            begin
                model_ids[i] = model_ids[i + 1];
                model_prios[i] = model_prios[i + 1];
            end
            model_count--;
            r.status = ST_EXTRACTED;
        end
        r.occupancy = model_count[CNT_W-1:0];
        return r;
    endfunction

    // Send one operation; the sender idles between bursts of random length.
    task automatic transfer_op(input func_t op, input logic [ID_BITS-1:0] id,
                               input logic [PRIO_BITS-1:0] pr);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        func <= op;
        task_id <= id;
        prio <= pr;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
        pending_dispatches.push_back(model_dispatch(op, id, pr));
    endtask

    // An extract right after reset must report an empty queue.
    task automatic test_extract_when_empty();
        transfer_op(FUNC_EXTRACT, 8'hFF, 8'hFF);
    endtask

    // Fill to capacity with extreme ids and priorities, then overflow once.
    task automatic test_fill_past_full();
        logic [ID_BITS-1:0]   fill_ids [QUEUE_DEPTH] = '{
            8'h00, 8'hFF, 8'hAA, 8'h55, 8'h01, 8'h80, 8'h7F, 8'h10,
            8'h20, 8'h33, 8'hCC, 8'h0F, 8'hF0, 8'h42, 8'h99, 8'hFE};
        logic [PRIO_BITS-1:0] fill_prios [QUEUE_DEPTH] = '{
            8'hFF, 8'h00, 8'h07, 8'h00, 8'h80, 8'h07, 8'hFF, 8'h01,
            8'h00, 8'hC8, 8'h07, 8'h40, 8'h01, 8'hFF, 8'h20, 8'h00};
        int i;
        for (i = 0; i < QUEUE_DEPTH; i++)
            transfer_op(FUNC_INSERT, fill_ids[i], fill_prios[i]);
        transfer_op(FUNC_INSERT, 8'hFF, 8'h00);
    endtask

    // Drain a few entries; equal priorities must leave in arrival order.
    task automatic test_tie_break_order();
        int i;
        for (i = 0; i < 5; i++)
            transfer_op(FUNC_EXTRACT, 8'h00, 8'hFF);
    endtask

    // Random segments biased toward filling or draining, some with narrow priorities.
    task automatic test_random_mix(input int n_items);
        int                   done;
        int                   seg_left;
        int                   insert_pct;
        int                   prio_hi;
        func_t                op;
        logic [ID_BITS-1:0]   id;
        logic [PRIO_BITS-1:0] pr;
        done = 0;
        seg_left = 0;
        insert_pct = 50;
        prio_hi = 255;
        while (done < n_items)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(8, 48);
                case ($urandom_range(0, 2))
                    0: insert_pct = 25;
                    1: insert_pct = 50;
                    default: insert_pct = 80;
                endcase
                prio_hi = ($urandom_range(0, 1) == 1) ? 3 : 255;
            end
            op = ($urandom_range(1, 100) <= insert_pct) ? FUNC_INSERT : FUNC_EXTRACT;
            id = ID_BITS'($urandom_range(0, 255));
            pr = PRIO_BITS'($urandom_range(0, prio_hi));
            transfer_op(op, id, pr);
            seg_left--;
            done++;
        end
    endtask

    // Receiver ready follows a pattern that is picked at random for each phase of random length.
    always @(negedge clk)
    begin
        if (rx_phase_left == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_phase_left <= $urandom_range(16, 96);
        end
        else
        begin
            rx_phase_left <= rx_phase_left - 1;
        end
        case (rx_mode)
            RX_ALWAYS:      out_ready <= 1'b1;
            RX_COIN:        out_ready <= ($urandom_range(0, 1) == 1);
            RX_EVERY_FIFTH: out_ready <= (rx_tick % 5 == 4);
            default:        out_ready <= ($urandom_range(0, 7) == 0);
        endcase
        rx_tick <= rx_tick + 1;
    end

    // Compare each result transfer with the oldest pending expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_dispatches.size() == 0)
            begin
                $error("result with nothing pending: id %0d prio %0d status %0d",
                       out_task_id, out_prio, status);
                error_count++;
            end
            else
            begin
                oldest_dispatch = pending_dispatches.pop_front();
                if (out_task_id !== oldest_dispatch.task_id)
                begin
                    $error("out_task_id: expected %0d, actual %0d",
                           oldest_dispatch.task_id, out_task_id);
                    error_count++;
                end
                if (out_prio !== oldest_dispatch.prio)
                begin
                    $error("out_prio: expected %0d, actual %0d",
                           oldest_dispatch.prio, out_prio);
                    error_count++;
                end
                if (status !== oldest_dispatch.status)
                begin
                    $error("status: expected %0d, actual %0d",
                           oldest_dispatch.status, status);
                    error_count++;
                end
                if (occupancy !== oldest_dispatch.occupancy)
                begin
                    $error("occupancy: expected %0d, actual %0d",
                           oldest_dispatch.occupancy, occupancy);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Reset, run the tests in turn, then wait for the last results.
    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_extract_when_empty();
        test_fill_past_full();
        test_tie_break_order();
        test_random_mix(RANDOM_ITEMS);

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_dispatches.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
